// ===== hdl/mbrr_pkg.sv =====
// Shared types and constants for the read-register responder.
// No dependencies; used by every module of the block.
package mbrr_pkg;

  localparam int REQ_LEN = 12;
  localparam int CNT_W = 7;          // clamped register count, up to MAX_REGS
  localparam int ADDR_LO = 30000;
  localparam int ADDR_HI = 39999;
  localparam int BASE_REG = 30001;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic OP_REQ = 1'b0;
  localparam logic OP_UPD = 1'b1;

  localparam logic CFG_IN_SWAP  = 1'b0;
  localparam logic CFG_OUT_SWAP = 1'b1;

  localparam logic [7:0] FUNC_HOLDING = 8'd3;
  localparam logic [7:0] FUNC_INPUT   = 8'd4;

  // Response header byte positions
  localparam logic [8:0] HB_TRANS_0 = 9'd0;
  localparam logic [8:0] HB_TRANS_1 = 9'd1;
  localparam logic [8:0] HB_PROTO_0 = 9'd2;
  localparam logic [8:0] HB_PROTO_1 = 9'd3;
  localparam logic [8:0] HB_LEN_0   = 9'd4;
  localparam logic [8:0] HB_LEN_1   = 9'd5;
  localparam logic [8:0] HB_UNIT    = 9'd6;
  localparam logic [8:0] HB_FUNC    = 9'd7;
  localparam logic [8:0] HB_NBYTES  = 9'd8;

  typedef struct packed {
    logic [15:0]      trans;
    logic [15:0]      proto;
    logic [7:0]       unit;
    logic [7:0]       func;
    logic [CNT_W-1:0] count;
    logic             clamped;
    logic             served;
    logic [15:0]      off;      // first register minus BASE_REG
  } mbrr_desc_t;

  typedef struct packed {
    logic        wr;
    logic [1:0]  idx;
    logic [15:0] word;
  } mbrr_upd_t;

endpackage

// ===== hdl/modbus_tcp_read_register_responder.sv =====
// A request passes the queue and busy_r before its first response byte is registered.
// Throughput: one request word per cycle while the two-entry descriptor queue has room;
// a response of N data bytes is 9+N bytes; the next is taken only after its last byte.
// Value updates are held off while any response is queued or being emitted.
// Reset (synchronous, rst_n low) clears byte count, queue, stored values and config bits.
// Top level: ties mbrr_front, mbrr_fifo and mbrr_back; depends on mbrr_pkg.
module modbus_tcp_read_register_responder #(
  parameter int MAX_REGS    = 16,
  parameter int VALUE_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rx_byte[7:0], value_index[9:8], value_word[25:10]
  input  logic [1:0]  in_tuser,   // op[0], frame_first[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte[7:0]
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // count_clamped[0]
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_wdata
);
  import mbrr_pkg::*;

  logic       in_swap_r;
  logic       out_swap_r;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  logic       back_busy;
  logic       pending;
  mbrr_desc_t f_desc;
  mbrr_desc_t q_desc;
  mbrr_upd_t  upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_swap_r  <= 1'b0;
      out_swap_r <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_IN_SWAP) begin
        in_swap_r <= cfg_wdata[0];
      end
      if (cfg_index == CFG_OUT_SWAP) begin
        out_swap_r <= cfg_wdata[0];
      end
    end
  end

  assign pending = !q_empty || back_busy;

  mbrr_front #(
    .MAX_REGS(MAX_REGS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_swap  (in_swap_r),
    .in_valid (in_tvalid),
    .in_user  (in_tuser),
    .in_data  (in_tdata),
    .in_ready (in_tready),
    .q_full   (q_full),
    .pending  (pending),
    .push     (push),
    .desc     (f_desc),
    .upd      (upd)
  );

  mbrr_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_desc),
    .pop   (pop),
    .rdata (q_desc),
    .full  (q_full),
    .empty (q_empty)
  );

  mbrr_back #(
    .VALUE_COUNT(VALUE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_swap  (out_swap_r),
    .upd       (upd),
    .q_empty   (q_empty),
    .q_desc    (q_desc),
    .pop       (pop),
    .busy      (back_busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_user  (out_tuser[0])
  );

  a_upd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == OP_UPD) |-> !pending)
    else $error("value update taken while a response was pending");

endmodule

// ===== hdl/mbrr_front.sv =====
// Front end: takes input words, collects request bytes, parses a full request and passes value updates on.
// Depends on mbrr_pkg; feeds mbrr_fifo and the value store in mbrr_back.
module mbrr_front #(
  parameter int MAX_REGS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_swap,
  input  logic               in_valid,
  input  logic [1:0]         in_user,
  input  logic [31:0]        in_data,
  output logic               in_ready,
  input  logic               q_full,
  input  logic               pending,
  output logic               push,
  output mbrr_pkg::mbrr_desc_t desc,
  output mbrr_pkg::mbrr_upd_t  upd
);
  import mbrr_pkg::*;

  logic       op;
  logic       first;
  logic [7:0] rx;
  logic       acc;
  logic       byte_acc;
  logic [3:0] wr_idx;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] bytes_r [REQ_LEN-1];
  logic [15:0] addr;
  logic [15:0] count16;

  function automatic logic [15:0] rd16(input logic [7:0] a, input logic [7:0] b,
                                       input logic swap);
    rd16 = swap ? {b, a} : {a, b};
  endfunction

  assign op    = in_user[0];
  assign first = in_user[1];
  assign rx    = in_data[7:0];

  // updates wait until no response is still reading the stored values
  assign in_ready = (op == OP_UPD) ? !pending : !q_full;
  assign acc      = in_valid && in_ready;
  assign byte_acc = acc && (op == OP_REQ);

  assign wr_idx  = (first || cnt_r >= 4'(REQ_LEN)) ? 4'd0 : cnt_r;
  assign push    = byte_acc && (wr_idx == 4'(REQ_LEN - 1));
  assign cnt_nxt = byte_acc ? (push ? 4'd0 : wr_idx + 4'd1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc && !push) begin
      bytes_r[wr_idx] <= rx;
    end
  end

  assign addr    = rd16(bytes_r[8], bytes_r[9], in_swap);
  assign count16 = rd16(bytes_r[10], rx, in_swap);

  always_comb begin
    desc.trans   = rd16(bytes_r[0], bytes_r[1], in_swap);
    desc.proto   = rd16(bytes_r[2], bytes_r[3], in_swap);
    desc.unit    = bytes_r[6];
    desc.func    = bytes_r[7];
    desc.clamped = count16 > 16'(MAX_REGS);
    desc.count   = desc.clamped ? CNT_W'(MAX_REGS) : CNT_W'(count16);
    desc.served  = (bytes_r[7] == FUNC_HOLDING || bytes_r[7] == FUNC_INPUT) &&
                   addr > 16'(ADDR_LO) && addr < 16'(ADDR_HI);
    desc.off     = addr - 16'(BASE_REG);
  end

  always_comb begin
    upd.wr   = acc && (op == OP_UPD);
    upd.idx  = in_data[9:8];
    upd.word = in_data[25:10];
  end

endmodule

// ===== hdl/mbrr_fifo.sv =====
// Short descriptor queue between request parsing and response emission.
// Depends on mbrr_pkg for the descriptor type and depth.
module mbrr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mbrr_pkg::mbrr_desc_t wdata,
  input  logic                 pop,
  output mbrr_pkg::mbrr_desc_t rdata,
  output logic                 full,
  output logic                 empty
);
  import mbrr_pkg::*;

  mbrr_desc_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  function automatic logic [Q_PTR_W-1:0] inc(input logic [Q_PTR_W-1:0] p);
    inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("descriptor queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("descriptor queue read while empty");

endmodule

// ===== hdl/mbrr_back.sv =====
// Back end: holds the measured values and emits one response byte per cycle while out_ready allows.
// Depends on mbrr_pkg; takes descriptors from mbrr_fifo.
module mbrr_back #(
  parameter int VALUE_COUNT = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 out_swap,
  input  mbrr_pkg::mbrr_upd_t  upd,
  input  logic                 q_empty,
  input  mbrr_pkg::mbrr_desc_t q_desc,
  output logic                 pop,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_data,
  output logic                 out_last,
  output logic                 out_user
);
  import mbrr_pkg::*;

  localparam int VI_W = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;

  logic [15:0] mv_r [VALUE_COUNT];
  mbrr_desc_t  d_r;
  logic        busy_r;
  logic [8:0]  idx_r;
  logic [8:0]  last_idx_r;
  logic [15:0] off_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        out_user_r;

  logic        adv;
  logic        is_last;
  logic [7:0]  nbytes;
  logic [15:0] len16;
  logic [15:0] word;
  logic [15:0] val;
  logic        hi_half;   // second byte of a 16-bit field
  logic [7:0]  byte_nxt;

  assign adv     = busy_r && (!out_valid_r || out_ready);
  assign is_last = (idx_r == last_idx_r);
  assign pop     = !busy_r && !q_empty;
  assign busy    = busy_r;

  assign nbytes = {d_r.count, 1'b0};
  assign len16  = {8'd0, nbytes + 8'd3};

  assign val = (d_r.served && off_r < 16'(VALUE_COUNT)) ? mv_r[VI_W'(off_r)] : 16'd0;

  always_comb begin
    word     = val;
    hi_half  = !idx_r[0];        // data bytes start at odd positions
    byte_nxt = 8'd0;
    case (idx_r)
      HB_TRANS_0, HB_TRANS_1: begin
        word    = d_r.trans;
        hi_half = idx_r[0];
      end
      HB_PROTO_0, HB_PROTO_1: begin
        word    = d_r.proto;
        hi_half = idx_r[0];
      end
      HB_LEN_0, HB_LEN_1: begin
        word    = len16;
        hi_half = idx_r[0];
      end
      default: begin
        word = val;
      end
    endcase
    byte_nxt = (hi_half ^ out_swap) ? word[7:0] : word[15:8];
    case (idx_r)
      HB_UNIT:   byte_nxt = d_r.unit;
      HB_FUNC:   byte_nxt = d_r.func;
      HB_NBYTES: byte_nxt = nbytes;
      default:   byte_nxt = byte_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VALUE_COUNT; i++) begin
        mv_r[i] <= '0;
      end
    end else if (upd.wr && 32'(upd.idx) < VALUE_COUNT) begin
      mv_r[VI_W'(upd.idx)] <= upd.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (adv && is_last) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      d_r        <= q_desc;
      idx_r      <= '0;
      last_idx_r <= 9'({q_desc.count, 1'b0}) + HB_NBYTES;
      off_r      <= q_desc.off;
    end else if (adv) begin
      idx_r <= idx_r + 9'd1;
      if (idx_r > HB_NBYTES && !idx_r[0]) begin
        off_r <= off_r + 16'd1;
      end
    end
    if (adv) begin
      out_data_r <= byte_nxt;
      out_last_r <= is_last;
      out_user_r <= d_r.clamped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_user  = out_user_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= last_idx_r)
    else $error("byte position ran past end of response");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (!busy_r || idx_r == '0))
    else $error("response still running after its final word");

endmodule
